/* sv/sdf_pkg.sv */
// Shared constants, types and arithmetic unit sizes for the SDF primitive evaluator.
`default_nettype none

package sdf_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 10;
  localparam int COORD_W   = 21;
  localparam int QUAT_FRAC = 14;
  localparam int DIST_W    = 24;
  localparam int CFG_W     = 64;
  localparam int LEN_W     = 20;

  // Pipelined restoring divider: one quotient bit per stage
  localparam int DIV_NUM_W = 52;
  localparam int DIV_DEN_W = 21;
  localparam int DIV_QUO_W = 32;
  localparam int DIV_LAT   = DIV_QUO_W + 1;

  // Pipelined integer square root: one root bit per stage
  localparam int SQRT_OUT_W = 32;
  localparam int SQRT_IN_W  = 2 * SQRT_OUT_W;
  localparam int SQRT_REM_W = SQRT_OUT_W + 2;
  localparam int SQRT_LAT   = SQRT_OUT_W + 1;

  typedef enum logic [2:0] {
    SHAPE_SPHERE   = 3'd0,
    SHAPE_BOX      = 3'd1,
    SHAPE_CAPSULE  = 3'd2,
    SHAPE_CYLINDER = 3'd3,
    SHAPE_CONE     = 3'd4,
    SHAPE_TORUS    = 3'd5
  } shape_kind_e;

  typedef enum logic [2:0] {
    CFG_CENTRE   = 3'd0,
    CFG_QUAT     = 3'd1,
    CFG_SCALE    = 3'd2,
    CFG_KIND     = 3'd3,
    CFG_RADIUS   = 3'd4,
    CFG_RADIUS2  = 3'd5,
    CFG_HEIGHT   = 3'd6,
    CFG_EXTENT   = 3'd7
  } cfg_idx_e;

  // Reset values: identity rotation, unit scale, unit sizes
  localparam logic [COORD_W-1:0]   ONE_COORD = COORD_W'(1 << FRAC_BITS);
  localparam logic [LEN_W-1:0]     ONE_LEN   = LEN_W'(1 << FRAC_BITS);
  localparam logic [CFG_W-1:0]     QUAT_RST  = {16'h4000, 48'h0};
  localparam logic [3*COORD_W-1:0] SCALE_RST = {ONE_COORD, ONE_COORD, ONE_COORD};

endpackage

`default_nettype wire

/* sv/sdf_div.sv */
// Pipelined unsigned restoring divider with quotient overflow detect.
`default_nettype none

module sdf_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [sdf_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [sdf_pkg::DIV_DEN_W-1:0]    den_i,
  output logic                             valid_o,
  output logic [sdf_pkg::DIV_QUO_W-1:0]    quo_o,
  output logic                             ovf_o
);
  import sdf_pkg::*;

  localparam int NST = DIV_QUO_W;

  logic [NST:0]           vld_q;
  logic [NST:0]           ovf_q;
  logic [DIV_DEN_W-1:0]   rem_q [NST+1];
  logic [DIV_QUO_W-1:0]   low_q [NST+1];
  logic [DIV_QUO_W-1:0]   quo_q [NST+1];
  logic [DIV_DEN_W-1:0]   den_q [NST+1];

  logic [DIV_DEN_W:0]     trial_w [NST];
  logic [DIV_DEN_W:0]     diff_w  [NST];
  logic [NST-1:0]         ge_w;
  logic [DIV_DEN_W-1:0]   rem_d   [NST];

  // one quotient bit per stage
  always_comb begin
    for (int k = 0; k < NST; k++) begin
      trial_w[k] = {rem_q[k], low_q[k][DIV_QUO_W-1]};
      diff_w[k]  = trial_w[k] - {1'b0, den_q[k]};
      ge_w[k]    = (trial_w[k] >= {1'b0, den_q[k]});
      rem_d[k]   = ge_w[k] ? diff_w[k][DIV_DEN_W-1:0] : trial_w[k][DIV_DEN_W-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-1:0], valid_i};
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q[0] <= DIV_DEN_W'(num_i[DIV_NUM_W-1:DIV_QUO_W]);
    low_q[0] <= num_i[DIV_QUO_W-1:0];
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    ovf_q[0] <= (DIV_DEN_W'(num_i[DIV_NUM_W-1:DIV_QUO_W]) >= den_i);
    for (int k = 0; k < NST; k++) begin
      rem_q[k+1] <= rem_d[k];
      low_q[k+1] <= {low_q[k][DIV_QUO_W-2:0], 1'b0};
      quo_q[k+1] <= {quo_q[k][DIV_QUO_W-2:0], ge_w[k]};
      den_q[k+1] <= den_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign valid_o = vld_q[NST];
  assign quo_o   = quo_q[NST];
  assign ovf_o   = ovf_q[NST];

endmodule

`default_nettype wire

/* sv/sdf_sqrt.sv */
// Pipelined floor integer square root, one root bit per stage.
`default_nettype none

module sdf_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [sdf_pkg::SQRT_IN_W-1:0]  rad_i,
  output logic                           valid_o,
  output logic [sdf_pkg::SQRT_OUT_W-1:0] root_o
);
  import sdf_pkg::*;

  localparam int NST = SQRT_OUT_W;

  logic [NST:0]            vld_q;
  logic [SQRT_IN_W-1:0]    rad_q [NST+1];
  logic [SQRT_REM_W-1:0]   rem_q [NST+1];
  logic [SQRT_OUT_W-1:0]   res_q [NST+1];

  logic [SQRT_REM_W+1:0]   cur_w   [NST];
  logic [SQRT_REM_W+1:0]   trial_w [NST];
  logic [SQRT_REM_W+1:0]   diff_w  [NST];
  logic [NST-1:0]          ge_w;

  // bring down two radicand bits, try 4*root+1
  always_comb begin
    for (int k = 0; k < NST; k++) begin
      cur_w[k]   = {rem_q[k], rad_q[k][SQRT_IN_W-1 -: 2]};
      trial_w[k] = {2'b00, res_q[k], 2'b01};
      diff_w[k]  = cur_w[k] - trial_w[k];
      ge_w[k]    = (cur_w[k] >= trial_w[k]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-1:0], valid_i};
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rad_q[0] <= rad_i;
    rem_q[0] <= '0;
    res_q[0] <= '0;
    for (int k = 0; k < NST; k++) begin
      rad_q[k+1] <= {rad_q[k][SQRT_IN_W-3:0], 2'b00};
      rem_q[k+1] <= ge_w[k] ? diff_w[k][SQRT_REM_W-1:0] : cur_w[k][SQRT_REM_W-1:0];
      res_q[k+1] <= {res_q[k][SQRT_OUT_W-2:0], ge_w[k]};
    end
  end

  assign valid_o = vld_q[NST];
  assign root_o  = res_q[NST];

endmodule

`default_nettype wire

/* sv/sdf_primitive_evaluator.sv */
// Top level: transform a world point into primitive space and evaluate its signed distance.
// Throughput: one point per cycle; busy stays low, so start is always taken.
// Latency is set by the per-axis scale dividers and the two chained square roots,
// each 33 stages deep (one quotient or root bit per stage).
// Reset clears configuration to identity transform and unit sizes and empties the pipe.
`default_nettype none

module sdf_primitive_evaluator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [sdf_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [sdf_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [sdf_pkg::COORD_W-1:0] point_z_i,
  input  logic                              cfg_we_i,
  input  sdf_pkg::cfg_idx_e                 cfg_idx_i,
  input  logic [sdf_pkg::CFG_W-1:0]         cfg_data_i,
  output logic                              valid_o,
  output logic signed [sdf_pkg::DIST_W-1:0] distance_o,
  output logic                              range_flag_o
);
  import sdf_pkg::*;

  localparam logic signed [35:0] DMAX = 36'sd8388607;
  localparam logic signed [35:0] DMIN = -36'sd8388608;
  localparam logic [30:0]        LOCAL_LIM = 31'(1) << 30;

  // ---------------------------------------------------------------- config
  logic [3*COORD_W-1:0] centre_q;
  logic [CFG_W-1:0]     quat_q;
  logic [3*COORD_W-1:0] scale_q;
  shape_kind_e          kind_q;
  logic [LEN_W-1:0]     radius_q, radius2_q, height_q, extent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q  <= '0;
      quat_q    <= QUAT_RST;
      scale_q   <= SCALE_RST;
      kind_q    <= SHAPE_SPHERE;
      radius_q  <= ONE_LEN;
      radius2_q <= ONE_LEN;
      height_q  <= ONE_LEN;
      extent_q  <= ONE_LEN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTRE:  centre_q  <= cfg_data_i[3*COORD_W-1:0];
        CFG_QUAT:    quat_q    <= cfg_data_i;
        CFG_SCALE:   scale_q   <= cfg_data_i[3*COORD_W-1:0];
        CFG_KIND:    kind_q    <= shape_kind_e'(cfg_data_i[2:0]);
        CFG_RADIUS:  radius_q  <= cfg_data_i[LEN_W-1:0];
        CFG_RADIUS2: radius2_q <= cfg_data_i[LEN_W-1:0];
        CFG_HEIGHT:  height_q  <= cfg_data_i[LEN_W-1:0];
        CFG_EXTENT:  extent_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // unpacked config fields
  logic signed [COORD_W-1:0] pt_w  [3];
  logic signed [COORD_W-1:0] cen_w [3];
  logic signed [COORD_W-1:0] scl_w [3];
  logic signed [16:0]        u_w   [3];
  logic signed [15:0]        qw_w;
  logic signed [15:0]        qraw_w [3];

  always_comb begin
    pt_w[0] = point_x_i;
    pt_w[1] = point_y_i;
    pt_w[2] = point_z_i;
    for (int i = 0; i < 3; i++) begin
      cen_w[i]  = $signed(centre_q[(2-i)*COORD_W +: COORD_W]);
      scl_w[i]  = $signed(scale_q[(2-i)*COORD_W +: COORD_W]);
      qraw_w[i] = $signed(quat_q[32-16*i +: 16]);
      u_w[i]    = -(17'(qraw_w[i]));
    end
    qw_w = $signed(quat_q[63:48]);
  end

  // ---------------------------------------------------------------- rotation
  logic [5:0] vs_q;
  logic signed [21:0] v1_q [3], v2_q [3], v3_q [3], v4_q [3];
  logic signed [38:0] pa2_q [3], pb2_q [3];
  logic signed [27:0] t3_q [3];
  logic signed [44:0] w4_q [3], xa4_q [3], xb4_q [3];
  logic signed [33:0] rv5_q [3];
  logic [43:0]        mag6_q [3];
  logic [DIV_DEN_W-1:0] den6_q [3];
  logic [2:0]         neg6_q;
  logic               zs6_q;

  logic signed [39:0] c1_w [3];
  logic signed [41:0] tt_w [3];
  logic signed [46:0] sm_w [3];
  logic signed [43:0] num_w [3];
  logic signed [21:0] sabs_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c1_w[i]   = 40'(pa2_q[i]) - 40'(pb2_q[i]);
      tt_w[i]   = (42'(c1_w[i]) <<< 1) + 42'sd8192;
      sm_w[i]   = 47'(w4_q[i]) + 47'(xa4_q[i]) - 47'(xb4_q[i]) + 47'sd8192;
      num_w[i]  = 44'(rv5_q[i]) <<< FRAC_BITS;
      sabs_w[i] = (scl_w[i] < 0) ? -(22'(scl_w[i])) : 22'(scl_w[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= '0;
    end else begin
      vs_q <= {vs_q[4:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      // offset from centre
      v1_q[i] <= 22'(pt_w[i]) - 22'(cen_w[i]);
      v2_q[i] <= v1_q[i];
      v3_q[i] <= v2_q[i];
      v4_q[i] <= v3_q[i];
      // first cross product terms
      pa2_q[i] <= 39'(u_w[(i+1)%3]) * 39'(v1_q[(i+2)%3]);
      pb2_q[i] <= 39'(u_w[(i+2)%3]) * 39'(v1_q[(i+1)%3]);
      // t = round(2*cross(u,v) >> 14)
      t3_q[i] <= 28'(tt_w[i] >>> QUAT_FRAC);
      // w*t and second cross product terms
      w4_q[i]  <= 45'(qw_w) * 45'(t3_q[i]);
      xa4_q[i] <= 45'(u_w[(i+1)%3]) * 45'(t3_q[(i+2)%3]);
      xb4_q[i] <= 45'(u_w[(i+2)%3]) * 45'(t3_q[(i+1)%3]);
      // rotated vector
      rv5_q[i] <= 34'(v4_q[i]) + 34'(sm_w[i] >>> QUAT_FRAC);
      // divider operands
      mag6_q[i] <= (num_w[i] < 0) ? 44'(-num_w[i]) : 44'(num_w[i]);
      den6_q[i] <= sabs_w[i][DIV_DEN_W-1:0];
      neg6_q[i] <= (rv5_q[i] < 0) ^ (scl_w[i] < 0);
    end
    zs6_q <= (scl_w[0] == 0) || (scl_w[1] == 0) || (scl_w[2] == 0);
  end

  // ---------------------------------------------------------------- scale divide
  typedef struct packed {
    logic [2:0] neg;
    logic       zs;
  } side_div_t;

  side_div_t sd_q [DIV_LAT];
  logic [2:0]           dvld_w;
  logic [DIV_QUO_W-1:0] dquo_w [3];
  logic [2:0]           dovf_w;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    sdf_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vs_q[5]),
      .num_i   (DIV_NUM_W'(mag6_q[g])),
      .den_i   (den6_q[g]),
      .valid_o (dvld_w[g]),
      .quo_o   (dquo_w[g]),
      .ovf_o   (dovf_w[g])
    );
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= '{neg: neg6_q, zs: zs6_q};
    for (int k = 1; k < DIV_LAT; k++) sd_q[k] <= sd_q[k-1];
  end

  // ---------------------------------------------------------------- local point
  logic [4:1] vp_q;  // P, A, B, C stages
  logic               vd_q;
  logic signed [32:0] p_q [3];
  logic               fsp_q, fsa_q, fsb_q, fsc_q, fsd_q;
  logic [30:0]        pm_w [3];
  logic               kbad_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pm_w[i] = (dovf_w[i] || (dquo_w[i] > DIV_QUO_W'(LOCAL_LIM))) ? LOCAL_LIM
                                                                    : dquo_w[i][30:0];
    end
    unique case (kind_q)
      SHAPE_SPHERE, SHAPE_BOX, SHAPE_CAPSULE,
      SHAPE_CYLINDER, SHAPE_TORUS: kbad_w = 1'b0;
      SHAPE_CONE:                  kbad_w = (height_q == '0);
      default:                     kbad_w = 1'b1;
    endcase
  end

  // shape preparation: stage A
  logic signed [32:0] hh_w, aabs_w [3], capo_w;
  logic signed [32:0] pa_q [3], bq_q [3], capo_q, dy_q, qy_q;

  always_comb begin
    hh_w = $signed({14'b0, height_q[LEN_W-1:1]});
    for (int i = 0; i < 3; i++) aabs_w[i] = (p_q[i] < 0) ? -p_q[i] : p_q[i];
    priority if (p_q[1] > hh_w)  capo_w = p_q[1] - hh_w;
    else if (p_q[1] < -hh_w)     capo_w = p_q[1] + hh_w;
    else                         capo_w = '0;
  end

  // stage B: square operands and side value
  logic signed [32:0] sel_w [3], aux_b_w, bmax_w;
  logic [31:0]        smag_q [3];
  logic signed [32:0] auxb_q, auxc_q, auxd_q;

  always_comb begin
    bmax_w = (bq_q[0] > bq_q[1]) ? bq_q[0] : bq_q[1];
    bmax_w = (bmax_w > bq_q[2]) ? bmax_w : bq_q[2];
    sel_w[0] = pa_q[0];
    sel_w[1] = pa_q[1];
    sel_w[2] = pa_q[2];
    aux_b_w  = '0;
    unique case (kind_q)
      SHAPE_SPHERE: ;
      SHAPE_BOX: begin
        for (int i = 0; i < 3; i++) sel_w[i] = (bq_q[i] > 0) ? bq_q[i] : '0;
        aux_b_w = (bmax_w < 0) ? bmax_w : '0;
      end
      SHAPE_CAPSULE: sel_w[1] = capo_q;
      SHAPE_CYLINDER: begin
        sel_w[1] = pa_q[2];
        sel_w[2] = '0;
        aux_b_w  = dy_q;
      end
      SHAPE_CONE: begin
        sel_w[1] = pa_q[2];
        sel_w[2] = '0;
        aux_b_w  = qy_q;
      end
      SHAPE_TORUS: begin
        sel_w[1] = pa_q[2];
        sel_w[2] = '0;
        aux_b_w  = pa_q[1];
      end
      default: ;
    endcase
  end

  // stage C/D: squares, cone product
  logic [63:0]        sq_q [3];
  logic signed [52:0] cp_q;
  logic [63:0]        sum_q;
  logic [51:0]        cmag_q;
  logic               cneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
      vd_q <= 1'b0;
    end else begin
      vp_q <= {vp_q[3:1], dvld_w[0] & dvld_w[1] & dvld_w[2]};
      vd_q <= vp_q[4];
    end
  end

  logic signed [32:0] selabs_w [3];
  always_comb begin
    for (int i = 0; i < 3; i++) selabs_w[i] = (sel_w[i] < 0) ? -sel_w[i] : sel_w[i];
  end

  always_ff @(posedge clk_i) begin
    // P: clamp and sign the quotients
    for (int i = 0; i < 3; i++) begin
      p_q[i] <= sd_q[DIV_LAT-1].neg[i] ? -(33'(pm_w[i])) : 33'(pm_w[i]);
    end
    fsp_q <= sd_q[DIV_LAT-1].zs | kbad_w;
    // A
    for (int i = 0; i < 3; i++) begin
      pa_q[i] <= p_q[i];
      bq_q[i] <= aabs_w[i] - $signed({13'b0, extent_q});
    end
    capo_q <= capo_w;
    dy_q   <= aabs_w[1] - hh_w;
    qy_q   <= p_q[1] + hh_w;
    fsa_q  <= fsp_q;
    // B
    for (int i = 0; i < 3; i++) smag_q[i] <= selabs_w[i][31:0];
    auxb_q <= aux_b_w;
    fsb_q  <= fsa_q;
    // C
    for (int i = 0; i < 3; i++) sq_q[i] <= 64'(smag_q[i]) * 64'(smag_q[i]);
    cp_q   <= 53'(auxb_q) * 53'($signed({1'b0, radius_q}));
    auxc_q <= auxb_q;
    fsc_q  <= fsb_q;
    // D
    sum_q  <= sq_q[0] + sq_q[1] + sq_q[2];
    cmag_q <= (cp_q < 0) ? 52'(-cp_q) : 52'(cp_q);
    cneg_q <= (cp_q < 0);
    auxd_q <= auxc_q;
    fsd_q  <= fsc_q;
  end

  // ---------------------------------------------------------------- first length
  typedef struct packed {
    logic               fs;
    logic               cneg;
    logic signed [32:0] aux;
  } side_len_t;

  side_len_t sl_q [SQRT_LAT];
  logic                  s1vld_w, cvld_w, covf_w;
  logic [SQRT_OUT_W-1:0] len1_w;
  logic [DIV_QUO_W-1:0]  cquo_w;

  sdf_sqrt u_len1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vd_q),
    .rad_i   (sum_q),
    .valid_o (s1vld_w),
    .root_o  (len1_w)
  );

  sdf_div u_cone_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vd_q),
    .num_i   (cmag_q),
    .den_i   ({1'b0, height_q}),
    .valid_o (cvld_w),
    .quo_o   (cquo_w),
    .ovf_o   (covf_w)
  );

  always_ff @(posedge clk_i) begin
    sl_q[0] <= '{fs: fsd_q, cneg: cneg_q, aux: auxd_q};
    for (int k = 1; k < SQRT_LAT; k++) sl_q[k] <= sl_q[k-1];
  end

  // stage E: first-level distances
  side_len_t          sle_w;
  logic signed [35:0] len_w, rr_w, base_w, qs_w, ed_w, ex_w;
  logic [32:0]        qmag_w;

  always_comb begin
    sle_w  = sl_q[SQRT_LAT-1];
    len_w  = $signed({4'b0, len1_w});
    rr_w   = $signed({16'b0, radius_q});
    base_w = len_w - rr_w;
    qmag_w = covf_w ? (33'(1) << 32) : {1'b0, cquo_w};
    qs_w   = sle_w.cneg ? -(36'(qmag_w)) : 36'(qmag_w);
    ex_w   = base_w;
    unique case (kind_q)
      SHAPE_BOX:   ed_w = len_w + 36'(sle_w.aux);
      SHAPE_CONE:  ed_w = base_w + qs_w;
      SHAPE_TORUS: begin
        ed_w = base_w;
        ex_w = len_w - $signed({16'b0, radius2_q});
      end
      default:     ed_w = base_w;
    endcase
  end

  logic               ve_q, vf_q, vg_q;
  logic signed [35:0] ed_q, ex_q, auxe_q;
  logic               fse_q, fsf_q, fsg_q;

  // stage F: second length operands
  logic signed [35:0] dd_w, x_w, y_w, extra_w, hs_w, c2_w, c3_w, xabs_w, yabs_w;
  logic               use2_w;

  always_comb begin
    hs_w    = $signed({16'b0, height_q});
    c2_w    = -auxe_q;
    c3_w    = auxe_q - hs_w;
    dd_w    = ed_q;
    x_w     = '0;
    y_w     = '0;
    extra_w = '0;
    use2_w  = 1'b0;
    unique case (kind_q)
      SHAPE_CONE: begin
        dd_w = (ed_q > c2_w) ? ed_q : c2_w;
        dd_w = (dd_w > c3_w) ? dd_w : c3_w;
      end
      SHAPE_CYLINDER: begin
        x_w     = (ex_q > 0) ? ex_q : '0;
        y_w     = (auxe_q > 0) ? auxe_q : '0;
        extra_w = (ex_q > auxe_q) ? ex_q : auxe_q;
        extra_w = (extra_w < 0) ? extra_w : '0;
        use2_w  = 1'b1;
      end
      SHAPE_TORUS: begin
        x_w     = ex_q;
        y_w     = auxe_q;
        extra_w = -$signed({16'b0, radius_q});
        use2_w  = 1'b1;
      end
      default: ;
    endcase
    xabs_w = (x_w < 0) ? -x_w : x_w;
    yabs_w = (y_w < 0) ? -y_w : y_w;
  end

  logic [31:0]        mx_q, my_q;
  logic signed [35:0] ddf_q, exf_q, ddg_q, exg_q;
  logic               use2f_q, use2g_q;
  logic [63:0]        sqx_q, sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else begin
      ve_q <= s1vld_w & cvld_w;
      vf_q <= ve_q;
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // E
    ed_q   <= ed_w;
    ex_q   <= ex_w;
    auxe_q <= 36'(sle_w.aux);
    fse_q  <= sle_w.fs;
    // F
    mx_q    <= xabs_w[31:0];
    my_q    <= yabs_w[31:0];
    ddf_q   <= dd_w;
    exf_q   <= extra_w;
    use2f_q <= use2_w;
    fsf_q   <= fse_q;
    // G
    sqx_q   <= 64'(mx_q) * 64'(mx_q);
    sqy_q   <= 64'(my_q) * 64'(my_q);
    ddg_q   <= ddf_q;
    exg_q   <= exf_q;
    use2g_q <= use2f_q;
    fsg_q   <= fsf_q;
  end

  // ---------------------------------------------------------------- second length
  typedef struct packed {
    logic               fs;
    logic               use2;
    logic signed [35:0] dd;
    logic signed [35:0] extra;
  } side_fin_t;

  side_fin_t             sf_q [SQRT_LAT];
  logic                  s2vld_w;
  logic [SQRT_OUT_W-1:0] len2_w;

  sdf_sqrt u_len2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vg_q),
    .rad_i   (sqx_q + sqy_q),
    .valid_o (s2vld_w),
    .root_o  (len2_w)
  );

  always_ff @(posedge clk_i) begin
    sf_q[0] <= '{fs: fsg_q, use2: use2g_q, dd: ddg_q, extra: exg_q};
    for (int k = 1; k < SQRT_LAT; k++) sf_q[k] <= sf_q[k-1];
  end

  // stage I: pick the distance
  side_fin_t          sfi_w;
  logic               vi_q, fsi_q;
  logic signed [35:0] di_q;

  assign sfi_w = sf_q[SQRT_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      vi_q    <= s2vld_w;
      valid_o <= vi_q;
    end
  end

  // output word with saturation
  always_ff @(posedge clk_i) begin
    di_q  <= sfi_w.use2 ? ($signed({4'b0, len2_w}) + sfi_w.extra) : sfi_w.dd;
    fsi_q <= sfi_w.fs;
    priority if (fsi_q || (di_q > DMAX)) begin
      distance_o   <= DMAX[DIST_W-1:0];
      range_flag_o <= 1'b1;
    end else if (di_q < DMIN) begin
      distance_o   <= DMIN[DIST_W-1:0];
      range_flag_o <= 1'b1;
    end else begin
      distance_o   <= di_q[DIST_W-1:0];
      range_flag_o <= 1'b0;
    end
  end

endmodule

`default_nettype wire
